>>> rtl/obbt_pkg.sv
// Shared constants and sequencer codes for the 2D oriented-box overlap tester.
`default_nettype none

package obbt_pkg;

  // Fixed field widths
  localparam int AxisW  = 16;  // Q1.14 signed axis components
  localparam int HalfW  = 23;  // Q15.8 unsigned half extents

  // Axis-by-axis dot: two 16x16 products summed, magnitude fits 32 bits
  localparam int DotW    = 2 * AxisW + 1;
  localparam int DotMagW = 2 * AxisW;

  // Alignment shifts to bring every term to Q.36
  localparam int ProjShift = 14;
  localparam int OwnShift  = 28;

  // Reach: own << 28 plus two 23x32 products
  localparam int TermW  = HalfW + DotMagW;
  localparam int ReachW = TermW + 2;

  // Sequencer state codes
  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  // Step counter covers four axes plus the final compare step
  localparam int          StepW    = 3;
  localparam logic [2:0]  StepLast = 3'd4;

endpackage : obbt_pkg

`default_nettype wire

>>> rtl/obb_overlap_test_2d.sv
// Top level: iterative separating-axis overlap test of two oriented 2D boxes.
// A test beat (action 1) steps through the four axes and the compare step, and
// the input stalls until it finishes. The two-stage axis unit (dot/projection
// multipliers, then half-extent multipliers and compare) runs once per axis.
// Store beats (action 0) give no result.
// Reset: asynchronous, active low; clears the stored box A to zero and idles.
`default_nettype none

module obb_overlap_test_2d
  import obbt_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // input channel
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire                           action_i,
  input  wire  signed [COORD_BITS-1:0]  center_x_i,
  input  wire  signed [COORD_BITS-1:0]  center_y_i,
  input  wire  signed [AxisW-1:0]       axis1_x_i,
  input  wire  signed [AxisW-1:0]       axis1_y_i,
  input  wire  signed [AxisW-1:0]       axis2_x_i,
  input  wire  signed [AxisW-1:0]       axis2_y_i,
  input  wire         [HalfW-1:0]       half_len1_i,
  input  wire         [HalfW-1:0]       half_len2_i,
  // output channel
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic                          overlap_o
);

  // Derived widths
  localparam int DiffW    = COORD_BITS + 1;
  localparam int ProjSumW = COORD_BITS + AxisW + 2;
  localparam int ProjMagW = COORD_BITS + AxisW + 1;
  localparam int ProjW    = ProjMagW + ProjShift;
  localparam int CmpW     = (ProjW > ReachW) ? ProjW : ReachW;

  // Stored box A
  logic signed [COORD_BITS-1:0] a_cx_q, a_cy_q;
  logic signed [AxisW-1:0]      a1x_q, a1y_q, a2x_q, a2y_q;
  logic        [HalfW-1:0]      ha1_q, ha2_q;

  // Latched box B and center difference
  logic signed [DiffW-1:0]      dx_q, dy_q;
  logic signed [AxisW-1:0]      b1x_q, b1y_q, b2x_q, b2y_q;
  logic        [HalfW-1:0]      hb1_q, hb2_q;

  // Sequencer
  logic             state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             sep_q, sep_d;
  logic             out_valid_q, out_valid_d;
  logic             overlap_q, overlap_d;

  // Axis unit stage registers
  logic [ProjMagW-1:0] proj_mag_q;
  logic [DotMagW-1:0]  dot1_mag_q, dot2_mag_q;
  logic [HalfW-1:0]    own_q, h1_q, h2_q;

  logic in_acc, can_finish, finish, st1_load;

  assign in_stall_o = (state_q == StRun);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign can_finish = !out_valid_q || !out_stall_i;
  assign finish     = (state_q == StRun) && (step_q == StepLast) && can_finish;
  assign st1_load   = (state_q == StRun) && (step_q != StepLast);

  // Store box A on a store beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_cx_q <= '0;
      a_cy_q <= '0;
      a1x_q  <= '0;
      a1y_q  <= '0;
      a2x_q  <= '0;
      a2y_q  <= '0;
      ha1_q  <= '0;
      ha2_q  <= '0;
    end else if (in_acc && !action_i) begin
      a_cx_q <= center_x_i;
      a_cy_q <= center_y_i;
      a1x_q  <= axis1_x_i;
      a1y_q  <= axis1_y_i;
      a2x_q  <= axis2_x_i;
      a2y_q  <= axis2_y_i;
      ha1_q  <= half_len1_i;
      ha2_q  <= half_len2_i;
    end
  end

  // Latch box B and the center difference on a test beat
  always_ff @(posedge clk_i) begin
    if (in_acc && action_i) begin
      dx_q  <= DiffW'(a_cx_q) - DiffW'(center_x_i);
      dy_q  <= DiffW'(a_cy_q) - DiffW'(center_y_i);
      b1x_q <= axis1_x_i;
      b1y_q <= axis1_y_i;
      b2x_q <= axis2_x_i;
      b2y_q <= axis2_y_i;
      hb1_q <= half_len1_i;
      hb2_q <= half_len2_i;
    end
  end

  // Stage 1 operand select: A's axes against B, then B's axes against A
  logic signed [AxisW-1:0] ux, uy, v1x, v1y, v2x, v2y;
  logic        [HalfW-1:0] own_s, h1_s, h2_s;

  always_comb begin
    unique case (step_q[1:0])
      2'd0: begin
        ux = a1x_q; uy = a1y_q; own_s = ha1_q;
      end
      2'd1: begin
        ux = a2x_q; uy = a2y_q; own_s = ha2_q;
      end
      2'd2: begin
        ux = b1x_q; uy = b1y_q; own_s = hb1_q;
      end
      default: begin
        ux = b2x_q; uy = b2y_q; own_s = hb2_q;
      end
    endcase
    if (!step_q[1]) begin
      v1x = b1x_q; v1y = b1y_q; h1_s = hb1_q;
      v2x = b2x_q; v2y = b2y_q; h2_s = hb2_q;
    end else begin
      v1x = a1x_q; v1y = a1y_q; h1_s = ha1_q;
      v2x = a2x_q; v2y = a2y_q; h2_s = ha2_q;
    end
  end

  // Stage 1: center projection and axis-by-axis dots
  logic signed [ProjSumW-1:0] proj_sum;
  logic signed [DotW-1:0]     dot1, dot2;

  always_comb begin
    proj_sum = ProjSumW'(dx_q) * ProjSumW'(ux) + ProjSumW'(dy_q) * ProjSumW'(uy);
    dot1     = DotW'(ux) * DotW'(v1x) + DotW'(uy) * DotW'(v1y);
    dot2     = DotW'(ux) * DotW'(v2x) + DotW'(uy) * DotW'(v2y);
  end

  always_ff @(posedge clk_i) begin
    if (st1_load) begin
      proj_mag_q <= ProjMagW'(proj_sum[ProjSumW-1] ? -proj_sum : proj_sum);
      dot1_mag_q <= DotMagW'(dot1[DotW-1] ? -dot1 : dot1);
      dot2_mag_q <= DotMagW'(dot2[DotW-1] ? -dot2 : dot2);
      own_q      <= own_s;
      h1_q       <= h1_s;
      h2_q       <= h2_s;
    end
  end

  // Stage 2: reach from half extents, strict compare against projection
  logic [TermW-1:0] term1, term2;
  logic [CmpW-1:0]  reach, proj;
  logic             sep_now;

  always_comb begin
    term1   = TermW'(h1_q) * TermW'(dot1_mag_q);
    term2   = TermW'(h2_q) * TermW'(dot2_mag_q);
    reach   = (CmpW'(own_q) << OwnShift) + CmpW'(term1) + CmpW'(term2);
    proj    = CmpW'(proj_mag_q) << ProjShift;
    sep_now = (proj > reach);
  end

  // Sequencer and output register
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    sep_d       = sep_q;
    out_valid_d = out_valid_q && out_stall_i;
    overlap_d   = overlap_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc && action_i) begin
          state_d = StRun;
          step_d  = '0;
          sep_d   = 1'b0;
        end
      end
      default: begin
        if (step_q != '0) begin
          sep_d = sep_q | sep_now;
        end
        if (step_q != StepLast) begin
          step_d = step_q + 1'b1;
        end else if (finish) begin
          state_d     = StIdle;
          step_d      = '0;
          out_valid_d = 1'b1;
          overlap_d   = !(sep_q | sep_now);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      sep_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      sep_q       <= sep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    overlap_q <= overlap_d;
  end

  assign out_valid_o = out_valid_q;
  assign overlap_o   = overlap_q;

  // Checks
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= StepLast)
    else $error("step counter out of range");

  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (step_q == '0))
    else $error("step counter not cleared while idle");

  a_finish_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (out_valid_q && state_q == StIdle))
    else $error("finished test did not present a result");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StRun && step_q == StepLast))
    else $error("result raised without a finished test");

endmodule : obb_overlap_test_2d

`default_nettype wire
